/* hw/rtl/cspc_pkg.sv */
// ----------------------------------------------------------------------------
// cspc_pkg
// shared types, constants and helper functions of the color space converter
// ----------------------------------------------------------------------------
package cspc_pkg;

    localparam int CHAN_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [7:0]  HALF_TURN   = 8'd180;
    localparam logic [4:0]  SECTOR_HALF = 5'd30;
    localparam logic [12:0] SECTOR_DEN  = 13'd7650;
    // floor(2^32 / 7650)
    localparam logic [19:0] SECTOR_RECIP = 20'd561433;

    typedef enum logic [2:0] {
        MODE_RGB2GRAY = 3'd0,
        MODE_GRAY2RGB = 3'd1,
        MODE_RGB2HSV  = 3'd2,
        MODE_HSV2RGB  = 3'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 2'd0,
        REG_WEIGHT_1 = 2'd1,
        REG_WEIGHT_2 = 2'd2,
        REG_WEIGHT_3 = 2'd3
    } reg_idx_t;

    localparam mode_t MODE_RESET = MODE_RGB2HSV;
    localparam logic [WEIGHT_W-1:0] WEIGHT_1_RESET = 16'd7471;
    localparam logic [WEIGHT_W-1:0] WEIGHT_2_RESET = 16'd38470;
    localparam logic [WEIGHT_W-1:0] WEIGHT_3_RESET = 16'd19589;

    // divider state between stages: partial remainder, shifting dividend/quotient, divisor
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] lq;
        logic [7:0] dvs;
    } div_t;

    typedef struct packed {
        logic [2:0] sec;
        logic [4:0] fr;
    } sector_t;

    // hue 0..179 into 30-step sector and fraction
    function automatic sector_t hue_split(input logic [7:0] hh);
        sector_t    res;
        logic [7:0] rest;
        res.sec = 3'd0;
        rest    = hh;
        for (int i = 0; i < 5; i++)
        begin
            if (rest >= {3'd0, SECTOR_HALF})
            begin
                rest    = rest - {3'd0, SECTOR_HALF};
                res.sec = res.sec + 3'd1;
            end
        end
        res.fr = rest[4:0];
        return res;
    endfunction

    // exact x / 255 for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

/* hw/rtl/cspc_if.sv */
// ----------------------------------------------------------------------------
// cspc interfaces
// pixel, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface cspc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;

    modport source (output valid, chan_first, chan_second, chan_third, input ready);
    modport sink   (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface cspc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic       bad_mode;

    modport source (output valid, out_first, out_second, out_third, bad_mode, input ready);
    modport sink   (input valid, out_first, out_second, out_third, bad_mode, output ready);
endinterface

interface cspc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/cspc_div_step.sv */
// ----------------------------------------------------------------------------
// cspc_div_step
// one registered stage of a restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module cspc_div_step (
    input  logic            clk,
    input  logic            en,
    input  cspc_pkg::div_t  din,
    output cspc_pkg::div_t  dout
);

    cspc_pkg::div_t dout_reg;
    cspc_pkg::div_t dout_next;

    always_comb
    begin
        logic [8:0] trial;
        dout_next = din;
        for (int i = 0; i < 2; i++)
        begin
            trial = {dout_next.rem, dout_next.lq[7]};
            if (trial >= {1'b0, dout_next.dvs})
            begin
                trial         = trial - {1'b0, dout_next.dvs};
                dout_next.lq  = {dout_next.lq[6:0], 1'b1};
            end
            else
            begin
                dout_next.lq  = {dout_next.lq[6:0], 1'b0};
            end
            dout_next.rem = trial[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

/* hw/rtl/color_space_pixel_converter.sv */
// ----------------------------------------------------------------------------
// color_space_pixel_converter
// gray, gray-to-rgb, rgb-to-hsv and hsv-to-rgb conversion of 8-bit pixels
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle; the whole pipeline holds while the result waits
// the two hsv divisions run through four 2-bit divider stages
// reset clears stage valid bits and loads the default mode and weights
// ----------------------------------------------------------------------------
module color_space_pixel_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    cspc_pixel_if.sink           pixel,
    cspc_result_if.source        result,
    cspc_cfg_if.sink             cfg
);

    // configuration
    cspc_pkg::mode_t mode_reg;
    logic [15:0]     w1_reg;
    logic [15:0]     w2_reg;
    logic [15:0]     w3_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cspc_pkg::MODE_RESET;
            w1_reg   <= cspc_pkg::WEIGHT_1_RESET;
            w2_reg   <= cspc_pkg::WEIGHT_2_RESET;
            w3_reg   <= cspc_pkg::WEIGHT_3_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cspc_pkg::reg_idx_t'(cfg.index))
                cspc_pkg::REG_MODE:     mode_reg <= cspc_pkg::mode_t'(cfg.data[2:0]);
                cspc_pkg::REG_WEIGHT_1: w1_reg   <= cfg.data;
                cspc_pkg::REG_WEIGHT_2: w2_reg   <= cfg.data;
                cspc_pkg::REG_WEIGHT_3: w3_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [6:0] vld_reg;
    logic       adv;

    assign adv         = !vld_reg[6] || result.ready;
    assign pixel.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], pixel.valid};
        end
    end

    // stage 1: max/min, gray products, hue sector
    logic [7:0]        mx_next;
    logic [7:0]        mn_next;
    logic [1:0]        sel_next;
    logic [7:0]        hh_next;
    cspc_pkg::sector_t sec_next;

    always_comb
    begin
        mx_next = (pixel.chan_first > pixel.chan_second) ? pixel.chan_first : pixel.chan_second;
        if (pixel.chan_third > mx_next)
        begin
            mx_next = pixel.chan_third;
        end
        mn_next = (pixel.chan_first < pixel.chan_second) ? pixel.chan_first : pixel.chan_second;
        if (pixel.chan_third < mn_next)
        begin
            mn_next = pixel.chan_third;
        end
        if (mx_next == pixel.chan_first)
        begin
            sel_next = 2'd0;
        end
        else if (mx_next == pixel.chan_second)
        begin
            sel_next = 2'd1;
        end
        else
        begin
            sel_next = 2'd2;
        end
        hh_next  = (pixel.chan_first >= cspc_pkg::HALF_TURN)
                 ? pixel.chan_first - cspc_pkg::HALF_TURN : pixel.chan_first;
        sec_next = cspc_pkg::hue_split(hh_next);
    end

    cspc_pkg::mode_t   mode1_reg;
    logic [7:0]        r1_reg, g1_reg, b1_reg;
    logic [7:0]        mx1_reg, d1_reg;
    logic [1:0]        sel1_reg;
    logic [23:0]       gp1_reg, gp2_reg, gp3_reg;
    cspc_pkg::sector_t sec1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= mode_reg;
            r1_reg    <= pixel.chan_first;
            g1_reg    <= pixel.chan_second;
            b1_reg    <= pixel.chan_third;
            mx1_reg   <= mx_next;
            d1_reg    <= mx_next - mn_next;
            sel1_reg  <= sel_next;
            gp1_reg   <= w1_reg * pixel.chan_first;
            gp2_reg   <= w2_reg * pixel.chan_second;
            gp3_reg   <= w3_reg * pixel.chan_third;
            sec1_reg  <= sec_next;
        end
    end

    // stage 2: gray sum, hue numerator, divider setup, rgb partial products
    logic [25:0]        gsum_next;
    logic [7:0]         gray_next;
    logic signed [17:0] rs, gs, bs, ds, hnum_next;
    logic [15:0]        snum_next;
    cspc_pkg::div_t     divs_next, divh_next;
    logic [7:0]         a0_next, a1_next, a2_next;

    always_comb
    begin
        gsum_next = {2'd0, gp1_reg} + {2'd0, gp2_reg} + {2'd0, gp3_reg};
        gray_next = (gsum_next[25:16] > {2'd0, cspc_pkg::FULL_SCALE})
                  ? cspc_pkg::FULL_SCALE : gsum_next[23:16];
        rs = signed'({10'd0, r1_reg});
        gs = signed'({10'd0, g1_reg});
        bs = signed'({10'd0, b1_reg});
        ds = signed'({10'd0, d1_reg});
        unique case (sel1_reg)
            2'd0:    hnum_next = (gs - bs) * 18'sd30;
            2'd1:    hnum_next = (bs - rs) * 18'sd30 + ds * 18'sd60;
            default: hnum_next = (rs - gs) * 18'sd30 + ds * 18'sd120;
        endcase
        if (hnum_next < 0)
        begin
            hnum_next = hnum_next + ds * 18'sd180;
        end
        snum_next     = d1_reg * cspc_pkg::FULL_SCALE;
        divs_next.rem = snum_next[15:8];
        divs_next.lq  = snum_next[7:0];
        divs_next.dvs = mx1_reg;
        divh_next.rem = hnum_next[15:8];
        divh_next.lq  = hnum_next[7:0];
        divh_next.dvs = d1_reg;
        a0_next = '0;
        a1_next = '0;
        a2_next = '0;
        unique case (mode1_reg)
            cspc_pkg::MODE_RGB2GRAY: a0_next = gray_next;
            cspc_pkg::MODE_GRAY2RGB:
            begin
                a0_next = r1_reg;
                a1_next = r1_reg;
                a2_next = r1_reg;
            end
            cspc_pkg::MODE_RGB2HSV:  a2_next = mx1_reg;
            default: ;
        endcase
    end

    cspc_pkg::mode_t   mode_p_reg [2:6];
    logic              zero_p_reg [2:6];
    logic [7:0]        a0_p_reg [2:6];
    logic [7:0]        a1_p_reg [2:6];
    logic [7:0]        a2_p_reg [2:6];
    cspc_pkg::div_t    divs2_reg, divh2_reg;
    cspc_pkg::sector_t sec_p_reg [2:5];
    logic [7:0]        v_p_reg [2:5];
    logic [12:0]       sfr2_reg, s30_2_reg;
    logic [15:0]       xp2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_p_reg[2] <= mode1_reg;
            zero_p_reg[2] <= (d1_reg == 8'd0);
            a0_p_reg[2]   <= a0_next;
            a1_p_reg[2]   <= a1_next;
            a2_p_reg[2]   <= a2_next;
            divs2_reg     <= divs_next;
            divh2_reg     <= divh_next;
            sec_p_reg[2]  <= sec1_reg;
            v_p_reg[2]    <= b1_reg;
            sfr2_reg      <= g1_reg * sec1_reg.fr;
            s30_2_reg     <= g1_reg * (cspc_pkg::SECTOR_HALF - sec1_reg.fr);
            xp2_reg       <= b1_reg * (cspc_pkg::FULL_SCALE - g1_reg);
            for (int k = 3; k <= 6; k++)
            begin
                mode_p_reg[k] <= mode_p_reg[k-1];
                zero_p_reg[k] <= zero_p_reg[k-1];
                a0_p_reg[k]   <= a0_p_reg[k-1];
                a1_p_reg[k]   <= a1_p_reg[k-1];
                a2_p_reg[k]   <= a2_p_reg[k-1];
            end
            for (int k = 3; k <= 5; k++)
            begin
                sec_p_reg[k] <= sec_p_reg[k-1];
                v_p_reg[k]   <= v_p_reg[k-1];
            end
        end
    end

    // stages 3..6: saturation and hue dividers
    cspc_pkg::div_t divs_st [3:6];
    cspc_pkg::div_t divh_st [3:6];

    cspc_div_step u_divs3 (.clk(clk), .en(adv), .din(divs2_reg),  .dout(divs_st[3]));
    cspc_div_step u_divs4 (.clk(clk), .en(adv), .din(divs_st[3]), .dout(divs_st[4]));
    cspc_div_step u_divs5 (.clk(clk), .en(adv), .din(divs_st[4]), .dout(divs_st[5]));
    cspc_div_step u_divs6 (.clk(clk), .en(adv), .din(divs_st[5]), .dout(divs_st[6]));
    cspc_div_step u_divh3 (.clk(clk), .en(adv), .din(divh2_reg),  .dout(divh_st[3]));
    cspc_div_step u_divh4 (.clk(clk), .en(adv), .din(divh_st[3]), .dout(divh_st[4]));
    cspc_div_step u_divh5 (.clk(clk), .en(adv), .din(divh_st[4]), .dout(divh_st[5]));
    cspc_div_step u_divh6 (.clk(clk), .en(adv), .din(divh_st[5]), .dout(divh_st[6]));

    // stages 3..6: hsv to rgb with reciprocal division by 7650
    logic [20:0] xq3_reg, xt3_reg, xq4_reg, xt4_reg;
    logic [7:0]  p_p_reg [3:5];
    logic [7:0]  eq4_reg, et4_reg, q5_reg, t5_reg;
    logic [7:0]  rgb0_6_reg, rgb1_6_reg, rgb2_6_reg;
    logic [39:0] eq_prod, et_prod;
    logic [20:0] rq_next, rt_next;
    logic [8:0]  q_next, t_next;

    always_comb
    begin
        eq_prod = xq3_reg * cspc_pkg::SECTOR_RECIP;
        et_prod = xt3_reg * cspc_pkg::SECTOR_RECIP;
        rq_next = xq4_reg - eq4_reg * cspc_pkg::SECTOR_DEN;
        rt_next = xt4_reg - et4_reg * cspc_pkg::SECTOR_DEN;
        q_next  = {1'b0, eq4_reg} + ((rq_next >= {8'd0, cspc_pkg::SECTOR_DEN}) ? 9'd1 : 9'd0);
        t_next  = {1'b0, et4_reg} + ((rt_next >= {8'd0, cspc_pkg::SECTOR_DEN}) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xq3_reg    <= v_p_reg[2] * (cspc_pkg::SECTOR_DEN - sfr2_reg);
            xt3_reg    <= v_p_reg[2] * (cspc_pkg::SECTOR_DEN - s30_2_reg);
            p_p_reg[3] <= cspc_pkg::div255(xp2_reg);
            xq4_reg    <= xq3_reg;
            xt4_reg    <= xt3_reg;
            eq4_reg    <= eq_prod[39:32];
            et4_reg    <= et_prod[39:32];
            p_p_reg[4] <= p_p_reg[3];
            q5_reg     <= q_next[7:0];
            t5_reg     <= t_next[7:0];
            p_p_reg[5] <= p_p_reg[4];
            case (sec_p_reg[5].sec)
                3'd0:
                begin
                    rgb0_6_reg <= v_p_reg[5]; rgb1_6_reg <= t5_reg; rgb2_6_reg <= p_p_reg[5];
                end
                3'd1:
                begin
                    rgb0_6_reg <= q5_reg; rgb1_6_reg <= v_p_reg[5]; rgb2_6_reg <= p_p_reg[5];
                end
                3'd2:
                begin
                    rgb0_6_reg <= p_p_reg[5]; rgb1_6_reg <= v_p_reg[5]; rgb2_6_reg <= t5_reg;
                end
                3'd3:
                begin
                    rgb0_6_reg <= p_p_reg[5]; rgb1_6_reg <= q5_reg; rgb2_6_reg <= v_p_reg[5];
                end
                3'd4:
                begin
                    rgb0_6_reg <= t5_reg; rgb1_6_reg <= p_p_reg[5]; rgb2_6_reg <= v_p_reg[5];
                end
                default:
                begin
                    rgb0_6_reg <= v_p_reg[5]; rgb1_6_reg <= p_p_reg[5]; rgb2_6_reg <= q5_reg;
                end
            endcase
        end
    end

    // stage 7: output register
    logic [7:0] o0_next, o1_next, o2_next;
    logic       bad_next;
    logic [7:0] o0_reg, o1_reg, o2_reg;
    logic       bad_reg;

    always_comb
    begin
        o0_next  = a0_p_reg[6];
        o1_next  = a1_p_reg[6];
        o2_next  = a2_p_reg[6];
        bad_next = 1'b0;
        unique case (mode_p_reg[6])
            cspc_pkg::MODE_RGB2GRAY, cspc_pkg::MODE_GRAY2RGB: ;
            cspc_pkg::MODE_RGB2HSV:
            begin
                o0_next = zero_p_reg[6] ? 8'd0 : divh_st[6].lq;
                o1_next = zero_p_reg[6] ? 8'd0 : divs_st[6].lq;
            end
            cspc_pkg::MODE_HSV2RGB:
            begin
                o0_next = rgb0_6_reg;
                o1_next = rgb1_6_reg;
                o2_next = rgb2_6_reg;
            end
            default:
            begin
                o0_next  = '0;
                o1_next  = '0;
                o2_next  = '0;
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o0_reg  <= o0_next;
            o1_reg  <= o1_next;
            o2_reg  <= o2_next;
            bad_reg <= bad_next;
        end
    end

    assign result.valid      = vld_reg[6];
    assign result.out_first  = o0_reg;
    assign result.out_second = o1_reg;
    assign result.out_third  = o2_reg;
    assign result.bad_mode   = bad_reg;

endmodule

/* hw/rtl/cspc_checker.sv */
// ----------------------------------------------------------------------------
// cspc_checker
// port-level checks of the color space converter, bound to the top level
// ----------------------------------------------------------------------------
module cspc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_first,
    input logic [7:0] out_second,
    input logic [7:0] out_third,
    input logic       bad_mode
);

    // invalid mode gives an all-zero pixel
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_mode |-> out_first == 8'd0 && out_second == 8'd0
                                  && out_third == 8'd0)
        else $error("bad mode result not zero");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

    // a waiting result does not let the pipeline move
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first)
                                    && $stable(out_second) && $stable(out_third))
        else $error("stalled result changed");

endmodule

bind color_space_pixel_converter cspc_checker u_cspc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pixel.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_first  (result.out_first),
    .out_second (result.out_second),
    .out_third  (result.out_third),
    .bad_mode   (result.bad_mode)
);

/* test/tb_color_space_pixel_converter.sv */
// ----------------------------------------------------------------------------
// tb_color_space_pixel_converter
// self-checking bench: a directed table, then random pixels under several
// register settings and idle/stall mixes, each result checked against a
// table value or an in-bench model of the four conversions and the bad-mode flag
// ----------------------------------------------------------------------------
module tb_color_space_pixel_converter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_BAD_LO = 3'd4;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;
    localparam int         N_DIR       = 22;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic       bad;
    } pix_out_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
        logic        chk;
        logic [7:0]  e1;
        logic [7:0]  e2;
        logic [7:0]  e3;
        logic        eb;
    } dir_row_t;

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd255, 8'd0, 8'd0, 1'b1, 8'd0, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd0, 8'd255, 8'd0, 1'b1, 8'd60, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd0, 8'd0, 8'd255, 1'b1, 8'd120, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd255, 8'd0, 8'd255, 1'b1, 8'd150, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_RGB2HSV, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd10, 8'd20, 8'd30, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2GRAY, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd255, 8'd255, 8'd255, 1'b1, 8'd254, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2GRAY, cspc_pkg::WEIGHT_1_RESET, cspc_pkg::WEIGHT_2_RESET,
          cspc_pkg::WEIGHT_3_RESET,
          8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2GRAY, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2GRAY, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          8'd1, 8'd2, 8'd3, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_RGB2GRAY, 16'h0000, 16'h0000, 16'h0000,
          8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_GRAY2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd200, 8'd17, 8'd99, 1'b1, 8'd200, 8'd200, 8'd200, 1'b0},
        '{cspc_pkg::MODE_GRAY2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd255, 8'd0, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd0, 8'd0, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd0, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd179, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd180, 8'd200, 8'd100, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{cspc_pkg::MODE_HSV2RGB, 16'h0000, 16'h0000, 16'h0000,
          8'd60, 8'd128, 8'd200, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{MODE_BAD_LO, 16'h0000, 16'h0000, 16'h0000,
          8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1},
        '{MODE_BAD_HI, 16'h0000, 16'h0000, 16'h0000,
          8'd12, 8'd34, 8'd56, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1}
    };

    logic clk;
    logic rst_n;

    cspc_pixel_if  pix_if ();
    cspc_result_if res_if ();
    cspc_cfg_if    cfg_if ();

    color_space_pixel_converter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    logic [2:0]  cur_mode;
    logic [15:0] cur_w1;
    logic [15:0] cur_w2;
    logic [15:0] cur_w3;
    pix_out_t    pending_px [$];
    int          errors;
    int          idle_pct;
    int          stall_pct;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic pix_out_t convert_pixel(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        pix_out_t res;
        int       mx;
        int       mn;
        int       d;
        int       num;
        int       hh;
        int       fr;
        int       v;
        int       s;
        int       p;
        int       q;
        int       t;
        int       sum;
        res = '0;
        case (cur_mode)
            cspc_pkg::MODE_RGB2GRAY:
            begin
                sum = (int'(cur_w1) * int'(a) + int'(cur_w2) * int'(b)
                       + int'(cur_w3) * int'(c)) >>> 16;
                res.first = (sum > 255) ? 8'd255 : sum[7:0];
            end
            cspc_pkg::MODE_GRAY2RGB:
            begin
                res.first  = a;
                res.second = a;
                res.third  = a;
            end
            cspc_pkg::MODE_RGB2HSV:
            begin
                mx = (a > b) ? a : b;
                mx = (mx > c) ? mx : c;
                mn = (a < b) ? a : b;
                mn = (mn < c) ? mn : c;
                d  = mx - mn;
                res.third = mx[7:0];
                if (mx != 0 && d != 0)
                begin
                    s = (d * 255) / mx;
                    res.second = s[7:0];
                    if (mx == a)
                        num = 30 * (int'(b) - int'(c));
                    else if (mx == b)
                        num = 30 * (int'(c) - int'(a)) + 60 * d;
                    else
                        num = 30 * (int'(a) - int'(b)) + 120 * d;
                    if (num < 0)
                        num = num + 180 * d;
                    num = num / d;
                    res.first = num[7:0];
                end
            end
            cspc_pkg::MODE_HSV2RGB:
            begin
                hh = a % 180;
                fr = hh % 30;
                s  = b;
                v  = c;
                p  = (v * (255 - s)) / 255;
                q  = (v * (7650 - s * fr)) / 7650;
                t  = (v * (7650 - s * (30 - fr))) / 7650;
                case (hh / 30)
                    0: res = '{v[7:0], t[7:0], p[7:0], 1'b0};
                    1: res = '{q[7:0], v[7:0], p[7:0], 1'b0};
                    2: res = '{p[7:0], v[7:0], t[7:0], 1'b0};
                    3: res = '{p[7:0], q[7:0], v[7:0], 1'b0};
                    4: res = '{t[7:0], p[7:0], v[7:0], 1'b0};
                    default: res = '{v[7:0], p[7:0], q[7:0], 1'b0};
                endcase
            end
            default: res.bad = 1'b1;
        endcase
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cspc_pkg::reg_idx_t idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            cspc_pkg::REG_MODE:     cur_mode = val[2:0];
            cspc_pkg::REG_WEIGHT_1: cur_w1   = val;
            cspc_pkg::REG_WEIGHT_2: cur_w2   = val;
            default:                cur_w3   = val;
        endcase
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                              input logic has_exp, input pix_out_t exp_px);
        pix_out_t pred;
        logic     took;
        while ($urandom_range(99) < idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.chan_first  <= a;
        pix_if.chan_second <= b;
        pix_if.chan_third  <= c;
        // ready only moves at the rising edge, so the mid-cycle value is the one the edge sees
        do
        begin
            @(negedge clk);
            took = pix_if.ready;
            @(posedge clk);
        end
        while (!took);
        pred = has_exp ? exp_px : convert_pixel(a, b, c);
        pending_px.push_back(pred);
    endtask

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    always @(posedge clk)
    begin
        pix_out_t got;
        pix_out_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = '{res_if.out_first, res_if.out_second, res_if.out_third,
                        res_if.bad_mode};
                if (pending_px.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = pending_px.pop_front();
                    if (got.first !== want.first)
                    begin
                        $display("%0t: out_first exp %h got %h", $time, want.first, got.first);
                        errors = errors + 1;
                    end
                    if (got.second !== want.second)
                    begin
                        $display("%0t: out_second exp %h got %h", $time, want.second,
                                 got.second);
                        errors = errors + 1;
                    end
                    if (got.third !== want.third)
                    begin
                        $display("%0t: out_third exp %h got %h", $time, want.third, got.third);
                        errors = errors + 1;
                    end
                    if (got.bad !== want.bad)
                    begin
                        $display("%0t: bad_mode exp %b got %b", $time, want.bad, got.bad);
                        errors = errors + 1;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        dir_row_t   row;
        pix_out_t   exp_px;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        int         pct_src [4];
        int         pct_dst [4];
        pct_src = '{0, 71, 0, 32};
        pct_dst = '{0, 0, 71, 32};
        errors             = 0;
        idle_pct           = 0;
        stall_pct          = 0;
        cur_mode           = cspc_pkg::MODE_RESET;
        cur_w1             = cspc_pkg::WEIGHT_1_RESET;
        cur_w2             = cspc_pkg::WEIGHT_2_RESET;
        cur_w3             = cspc_pkg::WEIGHT_3_RESET;
        rst_n              = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.chan_first  = '0;
        pix_if.chan_second = '0;
        pix_if.chan_third  = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = cspc_pkg::REG_MODE;
        cfg_if.data        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, registers rewritten only when a row changes them
        for (int i = 0; i < N_DIR; i++)
        begin
            row = DIR_TAB[i];
            if (row.mode != cur_mode || row.w1 != cur_w1 || row.w2 != cur_w2
                || row.w3 != cur_w3)
            begin
                pix_if.valid <= 1'b0;
                @(posedge clk);
                wait_drained();
                if (row.mode != cur_mode)
                    write_reg(cspc_pkg::REG_MODE, {13'd0, row.mode});
                if (row.w1 != cur_w1)
                    write_reg(cspc_pkg::REG_WEIGHT_1, row.w1);
                if (row.w2 != cur_w2)
                    write_reg(cspc_pkg::REG_WEIGHT_2, row.w2);
                if (row.w3 != cur_w3)
                    write_reg(cspc_pkg::REG_WEIGHT_3, row.w3);
            end
            exp_px = '{row.e1, row.e2, row.e3, row.eb};
            send_pixel(row.c1, row.c2, row.c3, row.chk, exp_px);
        end

        // random part
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int blk = 0; blk < 6; blk++)
            begin
                pix_if.valid <= 1'b0;
                @(posedge clk);
                wait_drained();
                idle_pct  = pct_src[ph];
                stall_pct = pct_dst[ph];
                if ($urandom_range(5) == 0)
                    write_reg(cspc_pkg::REG_MODE, 16'($urandom_range(7)));
                else
                    write_reg(cspc_pkg::REG_MODE, 16'($urandom_range(3)));
                write_reg(cspc_pkg::REG_WEIGHT_1, pick_weight());
                write_reg(cspc_pkg::REG_WEIGHT_2, pick_weight());
                write_reg(cspc_pkg::REG_WEIGHT_3, pick_weight());
                for (int k = 0; k < 56; k++)
                begin
                    if (blk == 0 && k == 28)
                    begin
                        pix_if.valid <= 1'b0;
                        @(posedge clk);
                        while (pending_px.size() != 0)
                            @(posedge clk);
                    end
                    a = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                    c = 8'($urandom_range(255));
                    case ($urandom_range(9))
                        0:
                        begin
                            b = a;
                            c = a;
                        end
                        1: b = a;
                        2: c = b;
                        3: a = 8'($urandom_range(1) * 255);
                        4: c = 8'($urandom_range(1) * 255);
                        default: ;
                    endcase
                    send_pixel(a, b, c, 1'b0, '0);
                end
            end
        end

        pix_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* color_space_pixel_converter.f */
hw/rtl/cspc_pkg.sv
hw/rtl/cspc_if.sv
hw/rtl/cspc_div_step.sv
hw/rtl/color_space_pixel_converter.sv
hw/rtl/cspc_checker.sv
test/tb_color_space_pixel_converter.sv
